// ===== rtl/imm_pkg.sv =====
// Shared definitions for the integer matrix multiplier.
// Command codes, field widths, default store size and the engine status struct.
// No dependencies.
package imm_pkg;

    localparam int DATA_W      = 32;
    localparam int DIM_W       = 7;
    localparam int COORD_W     = 6;
    localparam int CMD_W       = 2;
    localparam int DEF_MAX_DIM = 64;

    typedef logic [CMD_W-1:0] t_cmd;

    localparam t_cmd CMD_WRITE_A = 2'd0;
    localparam t_cmd CMD_WRITE_B = 2'd1;
    localparam t_cmd CMD_COMPUTE = 2'd2;
    localparam t_cmd CMD_READ_C  = 2'd3;

    typedef struct packed {
        logic busy;
        logic done;
    } t_eng_stat;

endpackage

// ===== rtl/imm_ab_mem.sv =====
// Operand store for A and B: one write port, two registered read ports.
// A lives in the lower half, B in the upper half. Depends on imm_pkg.
module imm_ab_mem
    import imm_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM,
    localparam int CELLS = MAX_DIM * MAX_DIM,
    localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic              i_wsel,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_a_addr,
    input  logic [AW-1:0]     i_b_addr,
    output logic [DATA_W-1:0] o_a_q,
    output logic [DATA_W-1:0] o_b_q
);

    localparam int DEPTH = 2 ** (AW + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[{i_wsel, i_waddr}] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_a_q <= r_mem[{1'b0, i_a_addr}];
            o_b_q <= r_mem[{1'b1, i_b_addr}];
        end
    end

endmodule

// ===== rtl/imm_c_mem.sv =====
// Result store for C: one write port, one registered read port.
// Depends on imm_pkg.
module imm_c_mem
    import imm_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM,
    localparam int CELLS = MAX_DIM * MAX_DIM,
    localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_q
);

    logic [DATA_W-1:0] r_mem [CELLS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_q <= r_mem[i_raddr];
        end
    end

endmodule

// ===== rtl/imm_engine.sv =====
// Compute sequencer and multiply-accumulate pipeline.
// Walks i, j, k, reads A/B, multiplies, accumulates and writes C. Depends on imm_pkg.
module imm_engine
    import imm_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM,
    localparam int CELLS = MAX_DIM * MAX_DIM,
    localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIM_W-1:0]  i_dim,
    output logic              o_rd_en,
    output logic [AW-1:0]     o_a_addr,
    output logic [AW-1:0]     o_b_addr,
    input  logic [DATA_W-1:0] i_a_q,
    input  logic [DATA_W-1:0] i_b_q,
    output logic              o_c_we,
    output logic [AW-1:0]     o_c_addr,
    output logic [DATA_W-1:0] o_c_data,
    output t_eng_stat         o_stat
);

    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int NW = $clog2(MAX_DIM + 1);

    function automatic logic [AW-1:0] elem_addr(input logic [IW-1:0] r,
                                                input logic [IW-1:0] c);
        elem_addr = AW'(32'(r) * MAX_DIM + 32'(c));
    endfunction

    // control
    logic          r_run, r_busy, r_done, r_v1, r_v2;
    logic [IW-1:0] r_i, r_j, r_k, r_last;
    logic [IW-1:0] n_i, n_j, n_k;

    // pipeline payload
    logic              r_first1, r_fin1, r_end1;
    logic              r_first2, r_fin2, r_end2;
    logic [AW-1:0]     r_cad1, r_cad2;
    logic [DATA_W-1:0] r_prod, r_acc;

    logic [NW-1:0]     w_n;
    logic              w_klast, w_jlast, w_ilast, w_end0;
    logic [DATA_W-1:0] w_sum;

    always_comb begin
        if (32'(i_dim) > MAX_DIM) begin
            w_n = NW'(MAX_DIM);
        end else begin
            w_n = NW'(i_dim);
        end
    end

    assign w_klast = (r_k == r_last);
    assign w_jlast = (r_j == r_last);
    assign w_ilast = (r_i == r_last);
    assign w_end0  = w_klast && w_jlast && w_ilast;

    // k innermost, then j, then i
    always_comb begin
        n_i = r_i;
        n_j = r_j;
        n_k = r_k;
        if (i_start) begin
            n_i = '0;
            n_j = '0;
            n_k = '0;
        end else if (r_run) begin
            if (w_klast) begin
                n_k = '0;
                if (w_jlast) begin
                    n_j = '0;
                    n_i = r_i + 1'b1;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end else begin
                n_k = r_k + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_i    <= '0;
            r_j    <= '0;
            r_k    <= '0;
            r_last <= '0;
        end else begin
            r_done <= (i_start && (w_n == '0)) || (r_v2 && r_end2);
            r_v1   <= r_run;
            r_v2   <= r_v1;
            r_i    <= n_i;
            r_j    <= n_j;
            r_k    <= n_k;
            if (r_run && w_end0) begin
                r_run <= 1'b0;
            end
            if (i_start) begin
                r_last <= IW'(w_n - 1'b1);
                if (w_n != '0) begin
                    r_run  <= 1'b1;
                    r_busy <= 1'b1;
                end
            end
            if (r_v2 && r_end2) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_rd_en  = r_run;
    assign o_a_addr = elem_addr(r_i, r_k);
    assign o_b_addr = elem_addr(r_k, r_j);

    always_ff @(posedge i_clk) begin
        r_first1 <= (r_k == '0);
        r_fin1   <= w_klast;
        r_end1   <= w_end0;
        r_cad1   <= elem_addr(r_i, r_j);

        r_first2 <= r_first1;
        r_fin2   <= r_fin1;
        r_end2   <= r_end1;
        r_cad2   <= r_cad1;
        r_prod   <= i_a_q * i_b_q;  // low word only, wraps mod 2^32

        if (r_v2) begin
            r_acc <= w_sum;
        end
    end

    assign w_sum    = r_first2 ? r_prod : r_acc + r_prod;
    assign o_c_we   = r_v2 && r_fin2;
    assign o_c_addr = r_cad2;
    assign o_c_data = w_sum;

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// ===== rtl/integer_matrix_multiply.sv =====
// Top level of the integer matrix multiplier, C = A x B, N x N, N from the dim register.
// Depends on imm_pkg, imm_ab_mem, imm_c_mem and imm_engine.
//
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------------------
//  command   | start, busy          | i_command, i_row, i_col, i_value
//  result    | o_strobe (no stall)  | o_data, o_compute_done
//  config    | i_cfg_we             | i_cfg_wdata (dim)
//
// Element writes and reads take one transaction per cycle while busy is low; a read result
// appears on the cycle after it is accepted (the C store read port is registered).
// A compute holds busy while it runs and its done result appears as busy falls: one
// multiply-accumulate per cycle, set by the two read ports of the A/B store. With N = 0
// the done result follows on the next cycle.
// Reset is synchronous, active low, and clears control state only; the
// element stores are not cleared. The receiver cannot stall results.
module integer_matrix_multiply
    import imm_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [CMD_W-1:0]         i_command,
    input  logic [COORD_W-1:0]       i_row,
    input  logic [COORD_W-1:0]       i_col,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     i_cfg_we,
    input  logic [DIM_W-1:0]         i_cfg_wdata,
    output logic                     o_strobe,
    output logic signed [DATA_W-1:0] o_data,
    output logic                     o_compute_done
);

    localparam int CELLS = MAX_DIM * MAX_DIM;
    localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;

    logic [DIM_W-1:0]  r_dim;
    logic              r_rd_valid, r_rd_ok;

    logic              w_accept, w_inside;
    logic [AW-1:0]     w_addr;
    logic              w_ab_we, w_ab_sel, w_c_rd, w_compute;

    logic              w_rd_en;
    logic [AW-1:0]     w_a_addr, w_b_addr;
    logic [DATA_W-1:0] w_a_q, w_b_q;
    logic              w_c_we;
    logic [AW-1:0]     w_c_waddr;
    logic [DATA_W-1:0] w_c_wdata, w_c_q;
    t_eng_stat         w_stat;

    assign w_accept = start && !busy;
    assign w_inside = (32'(i_row) < MAX_DIM) && (32'(i_col) < MAX_DIM);
    assign w_addr   = AW'(32'(i_row) * MAX_DIM + 32'(i_col));

    always_comb begin
        w_ab_we   = 1'b0;
        w_ab_sel  = 1'b0;
        w_c_rd    = 1'b0;
        w_compute = 1'b0;
        case (i_command)
            CMD_WRITE_A: begin
                w_ab_we = w_accept && w_inside;
            end
            CMD_WRITE_B: begin
                w_ab_we  = w_accept && w_inside;
                w_ab_sel = 1'b1;
            end
            CMD_COMPUTE: begin
                w_compute = w_accept;
            end
            CMD_READ_C: begin
                w_c_rd = w_accept;
            end
            default: begin
                w_c_rd = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim      <= DIM_W'(1);
            r_rd_valid <= 1'b0;
            r_rd_ok    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_dim <= i_cfg_wdata;
            end
            r_rd_valid <= w_c_rd;
            r_rd_ok    <= w_c_rd && w_inside;
        end
    end

    imm_ab_mem #(
        .MAX_DIM (MAX_DIM)
    ) u_ab_mem (
        .i_clk    (i_clk),
        .i_we     (w_ab_we),
        .i_wsel   (w_ab_sel),
        .i_waddr  (w_addr),
        .i_wdata  ($unsigned(i_value)),
        .i_rd_en  (w_rd_en),
        .i_a_addr (w_a_addr),
        .i_b_addr (w_b_addr),
        .o_a_q    (w_a_q),
        .o_b_q    (w_b_q)
    );

    imm_engine #(
        .MAX_DIM (MAX_DIM)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_compute),
        .i_dim    (r_dim),
        .o_rd_en  (w_rd_en),
        .o_a_addr (w_a_addr),
        .o_b_addr (w_b_addr),
        .i_a_q    (w_a_q),
        .i_b_q    (w_b_q),
        .o_c_we   (w_c_we),
        .o_c_addr (w_c_waddr),
        .o_c_data (w_c_wdata),
        .o_stat   (w_stat)
    );

    imm_c_mem #(
        .MAX_DIM (MAX_DIM)
    ) u_c_mem (
        .i_clk   (i_clk),
        .i_we    (w_c_we),
        .i_waddr (w_c_waddr),
        .i_wdata (w_c_wdata),
        .i_rd_en (w_c_rd),
        .i_raddr (w_addr),
        .o_q     (w_c_q)
    );

    assign busy           = w_stat.busy;
    assign o_strobe       = r_rd_valid || w_stat.done;
    assign o_compute_done = w_stat.done;
    assign o_data         = r_rd_ok ? $signed(w_c_q) : '0;

    // a read result and a compute done can never share a cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_rd_valid && w_stat.done))
        else $error("read result collides with compute done");

    // no result leaves while a compute is running
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_strobe)
        else $error("result strobe while busy");

    // an accepted read gives its result on the next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_command == CMD_READ_C) |=> (o_strobe && !o_compute_done))
        else $error("read transaction gave no result");

    // the C store is only written while a compute is in flight
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_c_we |-> busy)
        else $error("C store written outside a compute");

endmodule
